>>> rtl/core/sbi_pkg.sv
package sbi_pkg;

    // coordinate width of every input field
    localparam int COORD_WIDTH = 16;
    // a difference of two coordinates needs one more bit
    localparam int DIFF_W = COORD_WIDTH + 1;
    // exact product of two differences
    localparam int PROD_W = 2 * DIFF_W;

    // stream widths: twelve coordinates padded to whole bytes, one flag byte out
    localparam int NUM_COORDS = 12;
    localparam int IN_W = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_W = 8;

    // two face planes on each of the three axes
    localparam int NUM_FACES = 6;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam diff_t DIFF_ZERO = '0;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // everything the face tests need, relative to the segment start
    typedef struct packed {
        diff_t [2:0] d;
        diff_t [2:0] lo_rel;
        diff_t [2:0] hi_rel;
        diff_t [2:0] den;
        diff_t [NUM_FACES-1:0] num;
    } prep_t;

    // signed product of two differences at full width
    function automatic prod_t mul_ext(diff_t a, diff_t b);
        prod_t ax;
        prod_t bx;
        ax = prod_t'(a);
        bx = prod_t'(b);
        return ax * bx;
    endfunction

endpackage

>>> rtl/core/sbi_prep.sv
module sbi_prep (
    input  logic                  clk,
    input  sbi_pkg::stage_en_t    en,
    input  sbi_pkg::coord_t [2:0] seg_start,
    input  sbi_pkg::coord_t [2:0] seg_end,
    input  sbi_pkg::coord_t [2:0] box_a,
    input  sbi_pkg::coord_t [2:0] box_b,
    output sbi_pkg::prep_t        prep_reg
);

    sbi_pkg::prep_t prep_next;
    sbi_pkg::coord_t [2:0] lo_c;
    sbi_pkg::coord_t [2:0] hi_c;
    logic [2:0] neg_c;

    // box ordering, differences and sign-normalized plane offsets
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_c[k] = (box_a[k] < box_b[k]) ? box_a[k] : box_b[k];
            hi_c[k] = (box_a[k] < box_b[k]) ? box_b[k] : box_a[k];
            neg_c[k] = seg_end[k] < seg_start[k];
            prep_next.d[k] = sbi_pkg::diff_t'(seg_end[k]) - sbi_pkg::diff_t'(seg_start[k]);
            prep_next.lo_rel[k] = sbi_pkg::diff_t'(lo_c[k]) - sbi_pkg::diff_t'(seg_start[k]);
            prep_next.hi_rel[k] = sbi_pkg::diff_t'(hi_c[k]) - sbi_pkg::diff_t'(seg_start[k]);
            prep_next.den[k] = neg_c[k]
                ? sbi_pkg::diff_t'(seg_start[k]) - sbi_pkg::diff_t'(seg_end[k])
                : sbi_pkg::diff_t'(seg_end[k]) - sbi_pkg::diff_t'(seg_start[k]);
            prep_next.num[2*k] = neg_c[k]
                ? sbi_pkg::diff_t'(seg_start[k]) - sbi_pkg::diff_t'(box_a[k])
                : sbi_pkg::diff_t'(box_a[k]) - sbi_pkg::diff_t'(seg_start[k]);
            prep_next.num[2*k+1] = neg_c[k]
                ? sbi_pkg::diff_t'(seg_start[k]) - sbi_pkg::diff_t'(box_b[k])
                : sbi_pkg::diff_t'(box_b[k]) - sbi_pkg::diff_t'(seg_start[k]);
        end
    end

    // stage 1 register
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prep_reg <= prep_next;
        end
    end

endmodule

>>> rtl/core/sbi_face.sv
module sbi_face (
    input  logic                 clk,
    input  sbi_pkg::stage_en_t   en,
    input  sbi_pkg::diff_t       num,
    input  sbi_pkg::diff_t       den,
    input  sbi_pkg::diff_t [2:0] d,
    input  sbi_pkg::diff_t [2:0] lo_rel,
    input  sbi_pkg::diff_t [2:0] hi_rel,
    output logic                 face_hit_reg
);

    sbi_pkg::prod_t [2:0] p_nd_reg;
    sbi_pkg::prod_t [2:0] p_lo_reg;
    sbi_pkg::prod_t [2:0] p_hi_reg;
    logic range_ok_reg;
    logic range_ok_next;
    logic face_hit_next;

    // crossing parameter lies in [0,1] and the axis is not flat
    assign range_ok_next = (num >= sbi_pkg::DIFF_ZERO) && (num <= den)
                           && (den != sbi_pkg::DIFF_ZERO);

    // stage 2: crossing point and box bounds, all scaled by den
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            range_ok_reg <= range_ok_next;
            for (int k = 0; k < 3; k++)
            begin
                p_nd_reg[k] <= sbi_pkg::mul_ext(num, d[k]);
                p_lo_reg[k] <= sbi_pkg::mul_ext(lo_rel[k], den);
                p_hi_reg[k] <= sbi_pkg::mul_ext(hi_rel[k], den);
            end
        end
    end

    // crossing point inside the closed box on every axis
    always_comb
    begin
        face_hit_next = range_ok_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (p_lo_reg[k] > p_nd_reg[k] || p_nd_reg[k] > p_hi_reg[k])
            begin
                face_hit_next = 1'b0;
            end
        end
    end

    // stage 3 register
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            face_hit_reg <= face_hit_next;
        end
    end

endmodule

>>> rtl/core/segment_box_intersect_test.sv
// Segment versus axis-aligned box hit test. Each transfer on s carries a 3D
// segment and a box given by two opposite corners in any order (signed Q8.8);
// each transfer on m returns one hit flag, set when the segment touches the
// closed box. Tests are exact: face crossings are compared by cross
// multiplication, never by division. The block takes one item per cycle
// through its three register stages (offsets, products, compares);
// back-pressure on m stalls the pipeline without loss and any empty stage
// keeps s_tready high.
module segment_box_intersect_test (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
    // box_a_x, box_a_y, box_a_z, box_b_x, box_b_y, box_b_z
    input  logic [sbi_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // hit, then zero padding
    output logic [sbi_pkg::OUT_W-1:0]   m_tdata
);

    localparam int CW = sbi_pkg::COORD_WIDTH;

    sbi_pkg::stage_en_t en;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v1_next;
    logic v2_next;
    logic v3_next;
    sbi_pkg::coord_t [2:0] seg_start;
    sbi_pkg::coord_t [2:0] seg_end;
    sbi_pkg::coord_t [2:0] box_a;
    sbi_pkg::coord_t [2:0] box_b;
    sbi_pkg::prep_t prep_q;
    logic ends2_reg;
    logic ends2_next;
    logic ends3_reg;
    logic [sbi_pkg::NUM_FACES-1:0] face_hit;
    logic hit;

    // unpack the input transfer
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            seg_start[k] = s_tdata[k*CW +: CW];
            seg_end[k] = s_tdata[(3+k)*CW +: CW];
            box_a[k] = s_tdata[(6+k)*CW +: CW];
            box_b[k] = s_tdata[(9+k)*CW +: CW];
        end
    end

    // stage enables: a stage loads when it is empty or its contents move on
    always_comb
    begin
        en.s3 = !v3_reg || m_tready;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
        v1_next = en.s1 ? s_tvalid : v1_reg;
        v2_next = en.s2 ? v1_reg : v2_reg;
        v3_next = en.s3 ? v2_reg : v3_reg;
    end

    assign s_tready = en.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // stage 1: offsets relative to the segment start
    sbi_prep u_prep (
        .clk       (clk),
        .en        (en),
        .seg_start (seg_start),
        .seg_end   (seg_end),
        .box_a     (box_a),
        .box_b     (box_b),
        .prep_reg  (prep_q)
    );

    // both endpoints inside the box
    always_comb
    begin
        ends2_next = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if (prep_q.lo_rel[k] > sbi_pkg::DIFF_ZERO || prep_q.hi_rel[k] < sbi_pkg::DIFF_ZERO
                || prep_q.lo_rel[k] > prep_q.d[k] || prep_q.d[k] > prep_q.hi_rel[k])
            begin
                ends2_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            ends2_reg <= ends2_next;
        end
        if (en.s3)
        begin
            ends3_reg <= ends2_reg;
        end
    end

    // stages 2 and 3: one tester per face plane
    for (genvar i = 0; i < sbi_pkg::NUM_FACES; i++)
    begin : g_face
        sbi_face u_face (
            .clk          (clk),
            .en           (en),
            .num          (prep_q.num[i]),
            .den          (prep_q.den[i/2]),
            .d            (prep_q.d),
            .lo_rel       (prep_q.lo_rel),
            .hi_rel       (prep_q.hi_rel),
            .face_hit_reg (face_hit[i])
        );
    end

    // result transfer
    assign hit = ends3_reg || (|face_hit);
    assign m_tvalid = v3_reg;
    assign m_tdata = sbi_pkg::OUT_W'(hit);

    // an empty first stage always takes a transfer
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_tready)
        else $error("first stage empty but input not ready");

    // an accepted transfer occupies stage 1 next cycle
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted transfer lost at stage 1");

    // a blocked middle stage keeps its item
    a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !en.s3) |=> v2_reg)
        else $error("stalled stage 2 item dropped");

endmodule

>>> bench/segment_box_intersect_test_tb.sv
`timescale 1ns / 1ps

module segment_box_intersect_test_tb;

    // one query: coordinate k sits at bits [16k +: 16] of s_tdata
    // 0..2 segment start, 3..5 segment end, 6..8 corner a, 9..11 corner b
    typedef sbi_pkg::coord_t [sbi_pkg::NUM_COORDS-1:0] query_t;

    typedef struct {
        query_t q;
        int     want;
    } query_row_t;

    localparam int USE_PREDICTOR = -1;
    localparam int RANDOM_QUERIES = 1850;
    localparam int GAP_MAX = 12;
    localparam int HOLD_AT = 600;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int SEG_START = 0;
    localparam int SEG_END = 3;
    localparam int CORNER_A = 6;
    localparam int CORNER_B = 9;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [sbi_pkg::IN_W-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [sbi_pkg::OUT_W-1:0]  m_tdata;

    // typed-in hit flag per offered query, USE_PREDICTOR where none is given
    int  typed_hit_q[$];
    // hit flags still owed by the block, oldest first
    bit  hit_due_q[$];
    int  mismatches = 0;
    int  offered = 0;

    segment_box_intersect_test u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // exact segment versus closed box test, crossings compared by cross multiplication
    function automatic bit segment_touches_box(query_t q);
        longint sp[3];
        longint ep[3];
        longint ca[3];
        longint cb[3];
        longint lo[3];
        longint hi[3];
        longint face;
        longint num;
        longint den;
        longint d;
        bit     hit;
        bit     in_box;
        int     ax;
        int     side;
        int     k;
        hit = 1'b0;
        in_box = 1'b1;
        for (k = 0; k < 3; k++)
        begin
            sp[k] = longint'($signed(q[SEG_START + k]));
            ep[k] = longint'($signed(q[SEG_END + k]));
            ca[k] = longint'($signed(q[CORNER_A + k]));
            cb[k] = longint'($signed(q[CORNER_B + k]));
            lo[k] = (ca[k] < cb[k]) ? ca[k] : cb[k];
            hi[k] = (ca[k] < cb[k]) ? cb[k] : ca[k];
            if (sp[k] < lo[k] || sp[k] > hi[k] || ep[k] < lo[k] || ep[k] > hi[k])
                in_box = 1'b0;
        end
        if (in_box)
            hit = 1'b1;
        // crossing of each face plane inside [0,1], crossing point inside the box
        for (ax = 0; ax < 3; ax++)
        begin
            for (side = 0; side < 2; side++)
            begin
                face = (side == 0) ? ca[ax] : cb[ax];
                num = face - sp[ax];
                den = ep[ax] - sp[ax];
                if (den < 0)
                begin
                    num = -num;
                    den = -den;
                end
                if (den != 0 && num >= 0 && num <= den)
                begin
                    in_box = 1'b1;
                    for (k = 0; k < 3; k++)
                    begin
                        d = ep[k] - sp[k];
                        if ((lo[k] - sp[k]) * den > num * d)
                            in_box = 1'b0;
                        if (num * d > (hi[k] - sp[k]) * den)
                            in_box = 1'b0;
                    end
                    if (in_box)
                        hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    function automatic query_row_t query_row(int sx, int sy, int sz, int ex, int ey, int ez,
                                             int ax, int ay, int az, int bx, int by, int bz,
                                             int want);
        query_row_t r;
        r.q = {sbi_pkg::coord_t'(bz), sbi_pkg::coord_t'(by), sbi_pkg::coord_t'(bx),
               sbi_pkg::coord_t'(az), sbi_pkg::coord_t'(ay), sbi_pkg::coord_t'(ax),
               sbi_pkg::coord_t'(ez), sbi_pkg::coord_t'(ey), sbi_pkg::coord_t'(ex),
               sbi_pkg::coord_t'(sz), sbi_pkg::coord_t'(sy), sbi_pkg::coord_t'(sx)};
        r.want = want;
        return r;
    endfunction

    function automatic sbi_pkg::coord_t clamp_coord(longint v);
        if (v > 32767)
            return sbi_pkg::coord_t'(32767);
        if (v < -32768)
            return sbi_pkg::coord_t'(-32768);
        return sbi_pkg::coord_t'(v);
    endfunction

    function automatic sbi_pkg::coord_t near(longint base, int span);
        return clamp_coord(base + longint'($urandom_range(2 * span)) - span);
    endfunction

    // boxes of random size and place, segments around them, with shape tweaks; some queries fully random
    function automatic query_t random_query();
        query_t q;
        longint ctr;
        int     span;
        int     shape;
        int     k;
        shape = $urandom_range(9);
        if (shape == 0)
        begin
            for (k = 0; k < sbi_pkg::NUM_COORDS; k++)
                q[k] = sbi_pkg::coord_t'($urandom);
            return q;
        end
        case ($urandom_range(3))
            0: span = 4;
            1: span = 64;
            2: span = 1024;
            default: span = 16384;
        endcase
        for (k = 0; k < 3; k++)
        begin
            ctr = longint'($urandom_range(65535)) - 32768;
            q[CORNER_A + k] = near(ctr, span);
            q[CORNER_B + k] = near(ctr, span);
            q[SEG_START + k] = near(ctr, 2 * span);
            q[SEG_END + k] = near(ctr, 2 * span);
        end
        k = $urandom_range(2);
        case (shape)
            // flat axis
            1: q[SEG_END + k] = q[SEG_START + k];
            // segment shrunk to a point
            2: q[SEG_END +: 3] = q[SEG_START +: 3];
            // box of zero extent on one axis
            3: q[CORNER_B + k] = q[CORNER_A + k];
            // an endpoint lying on a face plane
            4: q[SEG_START + k] = $urandom_range(1) ? q[CORNER_A + k] : q[CORNER_B + k];
            5: q[SEG_END + k] = $urandom_range(1) ? q[CORNER_A + k] : q[CORNER_B + k];
            default: ;
        endcase
        return q;
    endfunction

    // offer one query on s, called and returning at a falling edge
    task automatic offer(query_t q, int want);
        int gap;
        gap = (offered % 300 < 80) ? 0 : $urandom_range(GAP_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata <= sbi_pkg::IN_W'(q);
        s_tvalid <= 1'b1;
        typed_hit_q.push_back(want);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        offered++;
        @(negedge clk);
    endtask

    // record each accepted query and check each returned flag
    always @(posedge clk)
    begin : check_transfers
        int     want;
        query_t q;
        bit     due;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                q = s_tdata[sbi_pkg::NUM_COORDS*sbi_pkg::COORD_WIDTH-1:0];
                want = typed_hit_q.pop_front();
                hit_due_q.push_back((want == USE_PREDICTOR) ? segment_touches_box(q)
                                                            : want[0]);
            end
            if (m_tvalid && m_tready)
            begin
                if (hit_due_q.size() == 0)
                begin
                    $error("unexpected result transfer, m_tdata %0h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    due = hit_due_q.pop_front();
                    if (m_tdata[0] !== due)
                    begin
                        $error("hit mismatch: expected %0d, actual %0d", due, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[sbi_pkg::OUT_W-1:1] !== '0)
                    begin
                        $error("padding mismatch: expected 0, actual %0h",
                               m_tdata[sbi_pkg::OUT_W-1:1]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // result side: random stalls, stall-free stretches and one long hold-off
    initial
    begin : result_side
        int taken;
        int stall;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else if (taken % 400 < 100)
                stall = 0;
            else
                stall = $urandom_range(GAP_MAX);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    // stimulus: directed table, then random queries
    initial
    begin : stimulus
        query_row_t rows[$];
        int         i;
        // point segment in point box at the origin
        rows.push_back(query_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        // segment wholly inside
        rows.push_back(query_row(100, 100, 100, 200, 200, 200, 0, 0, 0, 1000, 1000, 1000, 1));
        // segment wholly outside
        rows.push_back(query_row(2000, 2000, 2000, 3000, 3000, 3000,
                                 0, 0, 0, 1000, 1000, 1000, 0));
        // straight through, corners given in reverse order
        rows.push_back(query_row(-2000, 500, 500, 2000, 500, 500,
                                 1000, 1000, 1000, 0, 0, 0, 1));
        // flat axis outside the box
        rows.push_back(query_row(-2000, 2000, 500, 2000, 2000, 500,
                                 0, 0, 0, 1000, 1000, 1000, 0));
        // point segment outside, then on a face
        rows.push_back(query_row(1500, 0, 0, 1500, 0, 0, 0, 0, 0, 1000, 1000, 1000, 0));
        rows.push_back(query_row(1000, 500, 500, 1000, 500, 500,
                                 0, 0, 0, 1000, 1000, 1000, 1));
        // point box on the segment
        rows.push_back(query_row(-100, -100, -100, 100, 100, 100, 0, 0, 0, 0, 0, 0, 1));
        // slab box pierced through its middle
        rows.push_back(query_row(500, 500, -500, 500, 500, 500, 0, 0, 0, 1000, 1000, 0, 1));
        // grazing an edge, then just past it
        rows.push_back(query_row(-100, 1100, 500, 100, 900, 500,
                                 0, 0, 0, 1000, 1000, 1000, 1));
        rows.push_back(query_row(-100, 1101, 500, 100, 901, 500,
                                 0, 0, 0, 1000, 1000, 1000, USE_PREDICTOR));
        // extremes of the coordinate range
        rows.push_back(query_row(-32768, -32768, -32768, -32768, -32768, -32768,
                                 -32768, -32768, -32768, -32768, -32768, -32768, 1));
        rows.push_back(query_row(32767, 32767, 32767, 32767, 32767, 32767,
                                 32767, 32767, 32767, 32767, 32767, 32767, 1));
        rows.push_back(query_row(-32768, -32768, -32768, 32767, 32767, 32767,
                                 -32768, -32768, -32768, 32767, 32767, 32767, 1));
        rows.push_back(query_row(-32768, -32768, -32768, 32767, 32767, 32767,
                                 0, 0, 0, 256, 256, 256, USE_PREDICTOR));
        rows.push_back(query_row(-32768, 32767, -32768, 32767, -32768, 32767,
                                 32767, 32767, 32767, 32767, 32767, 32767, 0));
        rows.push_back(query_row(32767, -32768, 0, -32768, 32767, 0,
                                 -256, -256, -256, 256, 256, 256, USE_PREDICTOR));
        // endpoint on a face, the other outside
        rows.push_back(query_row(1000, 500, 500, 2000, 500, 500,
                                 0, 0, 0, 1000, 1000, 1000, 1));
        // stops one step short of the face
        rows.push_back(query_row(-1000, 500, 500, -1, 500, 500,
                                 0, 0, 0, 1000, 1000, 1000, 0));
        // running along a face plane
        rows.push_back(query_row(-500, 0, 500, 1500, 0, 500, 0, 0, 0, 1000, 1000, 1000, 1));
        // through in the negative direction
        rows.push_back(query_row(2000, 500, 500, -2000, 500, 500,
                                 0, 0, 0, 1000, 1000, 1000, 1));
        // diagonal beside the box
        rows.push_back(query_row(1100, -100, 500, 1300, 100, 500,
                                 0, 0, 0, 1000, 1000, 1000, 0));
        // diagonal near a point box
        rows.push_back(query_row(0, 0, 0, 10, 10, 11, 5, 5, 5, 5, 5, 5, USE_PREDICTOR));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (i = 0; i < rows.size(); i++)
            offer(rows[i].q, rows[i].want);
        for (i = 0; i < RANDOM_QUERIES; i++)
            offer(random_query(), USE_PREDICTOR);
        s_tvalid <= 1'b0;

        // drain, then let a few more cycles pass for stray transfers
        while (hit_due_q.size() != 0 || typed_hit_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
